>>> src/mcac_pkg.sv
// shared types and constants of the multichannel autocorrelator
// no dependencies; used by the interfaces, the divider, the core and the verification files
package mcac_pkg;

    localparam int DEF_MAX_LAGS     = 64;
    localparam int DEF_MAX_CHANNELS = 8;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int LAG_W    = 6;
    localparam int CHAN_W   = 3;
    localparam int MEAN_W   = 64;
    localparam int COUNT_W  = 32;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic {
        REG_NUM_LAGS     = 1'b0,
        REG_NUM_CHANNELS = 1'b1
    } t_reg_index;

endpackage

>>> src/mcac_ifs.sv
// valid/ready channel interfaces of the multichannel autocorrelator
// depends on mcac_pkg for field widths
interface mcac_in_if;
    import mcac_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [VALUE_W-1:0]  sample_value;
    logic [LAG_W-1:0]           lag_index;
    logic [CHAN_W-1:0]          channel_index;

    modport source (output valid, action, sample_value, lag_index, channel_index,
                    input ready);
    modport sink   (input valid, action, sample_value, lag_index, channel_index,
                    output ready);
endinterface

interface mcac_out_if;
    import mcac_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [MEAN_W-1:0]   mean_product;
    logic [COUNT_W-1:0]         lag_count;
    logic                       saturated;

    modport source (output valid, mean_product, lag_count, saturated, input ready);
    modport sink   (input valid, mean_product, lag_count, saturated, output ready);
endinterface

>>> src/mcac_div.sv
// iterative signed 64 by unsigned 32 divider, one quotient bit per cycle
// depends on mcac_pkg for widths
module mcac_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [mcac_pkg::MEAN_W-1:0]  i_dividend,
    input  logic [mcac_pkg::COUNT_W-1:0]        i_divisor,
    output logic                                o_done,
    output logic signed [mcac_pkg::MEAN_W-1:0]  o_quotient
);
    import mcac_pkg::*;

    localparam int STEP_W = $clog2(MEAN_W);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [COUNT_W-1:0] r_rem;
    logic [MEAN_W-1:0]  r_quo;
    logic [COUNT_W-1:0] r_den;
    logic               r_neg;

    logic [COUNT_W:0]   shifted;
    logic               fits;
    logic [COUNT_W:0]   diff;

    assign shifted = {r_rem, r_quo[MEAN_W-1]};
    assign fits    = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_den  <= i_divisor;
                r_neg  <= i_dividend[MEAN_W-1];
                r_quo  <= i_dividend[MEAN_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
                r_quo  <= {r_quo[MEAN_W-2:0], fits};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(MEAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? signed'(~r_quo + 1'b1) : signed'(r_quo);

endmodule

>>> src/multichannel_autocorrelator_core.sv
// multichannel time autocorrelator core: ring of samples and lag accumulators
// depends on mcac_pkg, mcac_ifs (channels) and mcac_div (mean divider)
//
// usage:
//   i_in carries items: push a channel value, read one lag of one channel,
//   or clear. o_out carries one result per read. psel/penable/pwrite/paddr
//   set num_lags (0x0) and num_channels (0x4); a write restarts the block.
// timing:
//   a push reads the product sum memory, multiplies and writes back one
//   lag per cycle through a three stage pipeline, which drains before the
//   next item is taken
//   a read passes one memory read, then the 64 step divider that forms
//   sum / count (skipped for a zero count), then the output register
// reset and clear:
//   after reset, a clear item or a register write the block sweeps all
//   MAX_LAGS * MAX_CHANNELS entries (512 by default) of the product sum
//   memory, one entry a cycle; i_in.ready stays low meanwhile
// stalls:
//   the result waits in the output register; pushes keep running while it
//   waits, a following read finishes its divide and then holds until taken
module multichannel_autocorrelator_core #(
    parameter int MAX_LAGS     = mcac_pkg::DEF_MAX_LAGS,
    parameter int MAX_CHANNELS = mcac_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mcac_in_if.sink                             i_in,
    mcac_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcac_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mcac_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mcac_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mcac_pkg::*;

    localparam int CELLS   = MAX_LAGS * MAX_CHANNELS;
    localparam int AW      = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SW      = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
    localparam int PW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW      = $clog2(MAX_LAGS + 1);
    localparam int NCW     = $clog2(MAX_CHANNELS + 1);
    localparam int LAG_CAP = (MAX_LAGS < 127) ? MAX_LAGS : 127;
    localparam int CH_CAP  = (MAX_CHANNELS < 15) ? MAX_CHANNELS : 15;
    localparam int LAG_DEF = (MAX_LAGS < 64) ? MAX_LAGS : 64;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CLEAR  = 6'b000010,
        ST_MAC    = 6'b000100,
        ST_RDWAIT = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_RESULT = 6'b100000
    } t_state;

    function automatic logic [AW-1:0] cell_of(input int row, input int col);
        return AW'(row * MAX_CHANNELS + col);
    endfunction

    t_state r_state, n_state;

    // configuration and sequence state
    logic [CW-1:0]      r_num_lags;
    logic [NCW-1:0]     r_num_ch;
    logic [SW-1:0]      r_newest;
    logic [CW-1:0]      r_fill;
    logic [COUNT_W-1:0] r_total;
    logic [PW-1:0]      r_chpos;
    logic [AW-1:0]      r_clr_addr;

    // push working registers
    logic [CW-1:0]              r_lag;
    logic [CW-1:0]              r_mac_fill;
    logic [SW-1:0]              r_slot;
    logic [PW-1:0]              r_ch;
    logic signed [VALUE_W-1:0]  r_v;

    // mac pipeline
    logic                       r_p1_valid;
    logic [AW-1:0]              r_p1_cell;
    logic                       r_p2_valid;
    logic [AW-1:0]              r_p2_cell;
    logic signed [MEAN_W-1:0]   r_p2_prod;
    logic [MEAN_W:0]            r_p2_sum;

    // memories: sample ring and {mark, product sum}
    logic [VALUE_W-1:0] r_ring [CELLS];
    logic [VALUE_W-1:0] r_ring_q;
    logic [MEAN_W:0]    r_sums [CELLS];
    logic [MEAN_W:0]    r_sum_q;

    // read path
    logic                       r_rd_ok;
    logic [COUNT_W-1:0]         r_rd_count;
    logic                       r_rd_sat;
    logic signed [MEAN_W-1:0]   r_mean;

    // output register
    logic                       r_out_valid;
    logic signed [MEAN_W-1:0]   r_out_mean;
    logic [COUNT_W-1:0]         r_out_count;
    logic                       r_out_sat;

    logic cfg_wr;
    logic accept;
    logic acc_push;
    logic acc_read;
    logic issue;
    logic out_free;

    logic [PW-1:0]      ch_now;
    logic [SW-1:0]      n_newest;
    logic [CW-1:0]      n_fill;
    logic [COUNT_W-1:0] n_total;
    logic [PW-1:0]      n_chpos;
    logic [COUNT_W-1:0] lag_ext;
    logic [COUNT_W-1:0] rd_count;
    logic               rd_ok;

    logic               ring_we;
    logic [AW-1:0]      ring_waddr;
    logic [AW-1:0]      ring_raddr;
    logic               sum_re;
    logic [AW-1:0]      sum_raddr;
    logic               sum_we;
    logic [AW-1:0]      sum_waddr;
    logic [MEAN_W:0]    sum_wdata;

    logic [MEAN_W-1:0]  acc_sum;
    logic               acc_ovf;

    logic               div_start;
    logic               div_done;
    logic signed [MEAN_W-1:0] div_quo;

    logic [6:0]         wr_lags;
    logic [3:0]         wr_ch;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_NUM_CHANNELS) ? CFG_DATA_W'(r_num_ch)
                                                   : CFG_DATA_W'(r_num_lags);

    // clamp written register values to the supported range
    assign wr_lags = (pwdata[6:0] < 7'd1) ? 7'd1 :
                     (pwdata[6:0] > 7'(LAG_CAP)) ? 7'(LAG_CAP) : pwdata[6:0];
    assign wr_ch   = (pwdata[3:0] < 4'd1) ? 4'd1 :
                     (pwdata[3:0] > 4'(CH_CAP)) ? 4'(CH_CAP) : pwdata[3:0];

    // no item is taken in the cycle a register write lands
    assign i_in.ready = (r_state == ST_IDLE) && !cfg_wr;
    assign accept     = i_in.valid && i_in.ready;
    assign acc_push   = accept && (i_in.action == ACT_PUSH);
    assign acc_read   = accept && (i_in.action == ACT_READ);
    assign issue      = (r_state == ST_MAC) && (r_lag < r_mac_fill);
    assign out_free   = !r_out_valid || o_out.ready;

    // start-of-sample bookkeeping for a push
    always_comb begin
        ch_now   = (32'(r_chpos) >= 32'(r_num_ch)) ? '0 : r_chpos;
        n_newest = r_newest;
        n_fill   = r_fill;
        n_total  = r_total;
        if (ch_now == '0) begin
            if (r_fill == '0) begin
                n_newest = '0;
            end else if (32'(r_newest) + 1 >= 32'(r_num_lags)) begin
                n_newest = '0;
            end else begin
                n_newest = r_newest + 1'b1;
            end
            if (r_fill < r_num_lags) begin
                n_fill = r_fill + 1'b1;
            end
            if (r_total != '1) begin
                n_total = r_total + 1'b1;
            end
        end
        n_chpos = (32'(ch_now) + 1 >= 32'(r_num_ch)) ? '0 : ch_now + 1'b1;
    end

    // read lookup: range check and lag count
    assign lag_ext  = COUNT_W'(i_in.lag_index);
    assign rd_ok    = (32'(i_in.lag_index) < 32'(r_num_lags)) &&
                      (32'(i_in.channel_index) < 32'(r_num_ch));
    assign rd_count = (r_total > lag_ext) ? (r_total - lag_ext) : '0;

    // memory ports
    assign ring_we    = acc_push;
    assign ring_waddr = cell_of(int'(n_newest), int'(ch_now));
    assign ring_raddr = cell_of(int'(r_slot), int'(r_ch));
    assign sum_re     = issue || acc_read;
    assign sum_raddr  = issue ? cell_of(int'(r_lag), int'(r_ch))
                              : cell_of(int'(i_in.lag_index), int'(i_in.channel_index));

    // saturating accumulate in the last pipeline stage
    assign acc_sum = r_p2_sum[MEAN_W-1:0] + r_p2_prod;
    assign acc_ovf = (r_p2_sum[MEAN_W-1] == r_p2_prod[MEAN_W-1]) &&
                     (acc_sum[MEAN_W-1] != r_p2_sum[MEAN_W-1]);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            sum_we    = 1'b1;
            sum_waddr = r_clr_addr;
            sum_wdata = '0;
        end else begin
            sum_we    = r_p2_valid;
            sum_waddr = r_p2_cell;
            if (acc_ovf) begin
                // clip to the signed limit on the side of the old sum
                sum_wdata = {1'b1, r_p2_sum[MEAN_W-1],
                             {(MEAN_W-1){~r_p2_sum[MEAN_W-1]}}};
            end else begin
                sum_wdata = {r_p2_sum[MEAN_W], acc_sum};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_waddr] <= i_in.sample_value;
        end
        if (issue) begin
            r_ring_q <= r_ring[ring_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_sums[sum_waddr] <= sum_wdata;
        end
        if (sum_re) begin
            r_sum_q <= r_sums[sum_raddr];
        end
    end

    // mac pipeline: memory data, then product, then write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= issue;
            r_p2_valid <= r_p1_valid;
        end
        r_p1_cell <= cell_of(int'(r_lag), int'(r_ch));
        r_p2_cell <= r_p1_cell;
        r_p2_prod <= r_v * signed'(r_ring_q);
        r_p2_sum  <= r_sum_q;
    end

    assign div_start = (r_state == ST_RDWAIT) && r_rd_ok && (r_rd_count != '0);

    mcac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (signed'(r_sum_q[MEAN_W-1:0])),
        .i_divisor  (r_rd_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        if (cfg_wr) begin
            n_state = ST_CLEAR;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_in.action)
                            ACT_PUSH:  n_state = ST_MAC;
                            ACT_READ:  n_state = ST_RDWAIT;
                            ACT_CLEAR: n_state = ST_CLEAR;
                            default:   n_state = ST_IDLE;
                        endcase
                    end
                end
                ST_CLEAR: begin
                    if (r_clr_addr == AW'(CELLS - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_MAC: begin
                    if (!issue && !r_p1_valid && !r_p2_valid) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_RDWAIT: begin
                    n_state = div_start ? ST_DIV : ST_RESULT;
                end
                ST_DIV: begin
                    if (div_done) begin
                        n_state = ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // control and sequence registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_num_lags  <= CW'(LAG_DEF);
            r_num_ch    <= NCW'(1);
            r_newest    <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_chpos     <= '0;
            r_lag       <= '0;
            r_mac_fill  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == REG_NUM_CHANNELS) begin
                    r_num_ch <= NCW'(wr_ch);
                end else begin
                    r_num_lags <= CW'(wr_lags);
                end
                r_newest   <= '0;
                r_fill     <= '0;
                r_total    <= '0;
                r_chpos    <= '0;
                r_clr_addr <= '0;
            end else begin
                if (r_state == ST_CLEAR) begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                if (acc_push) begin
                    r_newest   <= n_newest;
                    r_fill     <= n_fill;
                    r_total    <= n_total;
                    r_chpos    <= n_chpos;
                    r_lag      <= '0;
                    r_mac_fill <= n_fill;
                end
                if (accept && (i_in.action == ACT_CLEAR)) begin
                    r_newest   <= '0;
                    r_fill     <= '0;
                    r_total    <= '0;
                    r_chpos    <= '0;
                    r_clr_addr <= '0;
                end
                if (issue) begin
                    r_lag <= r_lag + 1'b1;
                end
                if ((r_state == ST_RESULT) && out_free) begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc_push) begin
            r_slot <= n_newest;
            r_ch   <= ch_now;
            r_v    <= i_in.sample_value;
        end
        if (issue) begin
            // walk back through the ring, wrapping at num_lags
            r_slot <= (r_slot == '0) ? SW'(r_num_lags - 1'b1) : r_slot - 1'b1;
        end
        if (acc_read) begin
            r_rd_ok    <= rd_ok;
            r_rd_count <= rd_ok ? rd_count : '0;
        end
        if (r_state == ST_RDWAIT) begin
            r_rd_sat <= r_rd_ok && r_sum_q[MEAN_W];
            r_mean   <= '0;
        end
        if ((r_state == ST_DIV) && div_done) begin
            r_mean <= div_quo;
        end
        if ((r_state == ST_RESULT) && out_free) begin
            r_out_mean  <= r_mean;
            r_out_count <= r_rd_count;
            r_out_sat   <= r_rd_sat;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.mean_product = r_out_mean;
    assign o_out.lag_count    = r_out_count;
    assign o_out.saturated    = r_out_sat;

endmodule

>>> src/mcac_checker.sv
// port-level assertions for the multichannel autocorrelator core
// depends on mcac_pkg; bound to multichannel_autocorrelator_core
module mcac_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic [mcac_pkg::ACTION_W-1:0]        in_action,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [mcac_pkg::MEAN_W-1:0]   out_mean,
    input logic [mcac_pkg::COUNT_W-1:0]         out_count,
    input logic                                 out_sat
);
    import mcac_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid right after reset");

    // a push, read or clear keeps the block busy, so no item is taken in the cycle after it
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready && (in_action != ACT_NOP)) |=> !in_ready)
        else $error("item taken while previous work still running");

    // a lag with no contributing samples reports a zero mean
    a_zero_count_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && (out_count == '0)) |-> (out_mean == '0))
        else $error("nonzero mean with zero count");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=>
            ($stable(out_mean) && $stable(out_count) && $stable(out_sat)))
        else $error("result changed while stalled");

endmodule

bind multichannel_autocorrelator_core mcac_checker u_mcac_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_action (i_in.action),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_mean  (o_out.mean_product),
    .out_count (o_out.lag_count),
    .out_sat   (o_out.saturated)
);

>>> verif/mcac_checker.sv
// result predictor and comparator for the multichannel autocorrelator
// depends on mcac_pkg and mcac_ifs; watches the item channels and register writes
module mcac_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mcac_in_if                                i_in,
    mcac_out_if                               o_out,
    input  logic                              i_cfg_wr,
    input  logic [mcac_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [mcac_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import mcac_pkg::*;

    localparam int LAGS  = DEF_MAX_LAGS;
    localparam int CHANS = DEF_MAX_CHANNELS;
    localparam int CELLS = LAGS * CHANS;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [COUNT_W-1:0]       count;
        logic                     sat;
    } t_corr;

    logic signed [VALUE_W-1:0] ring [CELLS];
    logic signed [MEAN_W-1:0]  sums [CELLS];
    logic                      marks [CELLS];
    int unsigned newest, fill, lags_in_use, chans_in_use, chan_pos;
    logic [COUNT_W-1:0] samples;
    t_corr expected_corr [$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_corr.size();

    function automatic void restart_state();
        for (int i = 0; i < CELLS; i++) begin
            sums[i]  = '0;
            marks[i] = 1'b0;
        end
        newest = 0; fill = 0; samples = '0; chan_pos = 0;
    endfunction

    function automatic void accumulate(logic signed [VALUE_W-1:0] v);
        int unsigned ch, slot, sum_idx;
        logic signed [MEAN_W-1:0] prod, acc, total;
        ch = (chan_pos >= chans_in_use) ? 0 : chan_pos;
        if (ch == 0) begin
            newest = (fill == 0) ? 0 : ((newest + 1 >= lags_in_use) ? 0 : newest + 1);
            if (fill < lags_in_use) fill++;
            if (samples != '1) samples++;
        end
        ring[newest*CHANS + ch] = v;
        slot = newest;
        for (int lag = 0; lag < fill; lag++) begin
            sum_idx = lag*CHANS + ch;
            prod    = 64'(v) * 64'(ring[slot*CHANS + ch]);
            acc     = sums[sum_idx];
            total   = acc + prod;
            if (acc[63] == prod[63] && total[63] != acc[63]) begin
                sums[sum_idx]  = acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                marks[sum_idx] = 1'b1;
            end else begin
                sums[sum_idx] = total;
            end
            slot = (slot == 0) ? lags_in_use - 1 : slot - 1;
        end
        chan_pos = (ch + 1 >= chans_in_use) ? 0 : ch + 1;
    endfunction

    function automatic t_corr lag_mean(int unsigned lag, int unsigned ch);
        t_corr r;
        logic [COUNT_W-1:0] cnt;
        r = '0;
        if (lag < lags_in_use && ch < chans_in_use) begin
            cnt = (samples > lag) ? samples - lag : '0;
            r.count = cnt;
            if (cnt != 0) r.mean = sums[lag*CHANS + ch] / $signed({32'd0, cnt});
            r.sat = marks[lag*CHANS + ch];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_corr got, want;
        int unsigned v;
        if (!i_rst_n) begin
            lags_in_use  = LAGS;
            chans_in_use = 1;
            restart_state();
            expected_corr.delete();
            fails = 0;
        end else begin
            if (i_cfg_wr) begin
                if (i_cfg_addr == 3'(4*REG_NUM_LAGS)) begin
                    v = i_cfg_data & 32'h7f;
                    lags_in_use = (v < 1) ? 1 : ((v > LAGS) ? LAGS : v);
                    restart_state();
                end else if (i_cfg_addr == 3'(4*REG_NUM_CHANNELS)) begin
                    v = i_cfg_data & 32'hf;
                    chans_in_use = (v < 1) ? 1 : ((v > CHANS) ? CHANS : v);
                    restart_state();
                end
            end
            if (o_out.valid && o_out.ready) begin
                got = '{o_out.mean_product, o_out.lag_count, o_out.saturated};
                if (expected_corr.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result %p", got);
                end else begin
                    want = expected_corr.pop_front();
                    if (got.mean !== want.mean || got.count !== want.count
                            || got.sat !== want.sat) begin
                        fails++;
                        if (fails <= 10)
                            $display("result mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (t_action'(i_in.action))
                    ACT_PUSH:  accumulate(i_in.sample_value);
                    ACT_READ:  expected_corr.push_back(
                                   lag_mean(i_in.lag_index, i_in.channel_index));
                    ACT_CLEAR: restart_state();
                    default: ;
                endcase
            end
        end
    end
endmodule

>>> verif/testbench.sv
// top of the multichannel autocorrelator testbench: clock, reset, stimulus, verdict
// depends on mcac_pkg, mcac_ifs, the core and mcac_scoreboard
module testbench;
    import mcac_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;
    int fail_count, pending;
    int send_idle_pct, recv_idle_pct;
    longint cycles;
    int unsigned chans_cfg;

    mcac_in_if  in_ch();
    mcac_out_if out_ch();

    multichannel_autocorrelator_core u_top (
        .i_clk, .i_rst_n, .i_in(in_ch), .o_out(out_ch),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    mcac_scoreboard u_checker (
        .i_clk, .i_rst_n, .i_in(in_ch), .o_out(out_ch),
        .i_cfg_wr(psel && penable && pwrite && pready),
        .i_cfg_addr(paddr), .i_cfg_data(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: stops a hung run and reports it as failed
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 2000000) begin
            $display("multichannel_autocorrelator_core verification failed");
            $finish;
        end
    end

    // receiver stalls at random, driven on the falling edge
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_NOP;
        in_ch.sample_value = '0;
        in_ch.lag_index = '0;
        in_ch.channel_index = '0;
        out_ch.ready = 1'b0;
        cycles = 0;
    end

    // one register write: setup cycle, then access cycle
    task automatic write_reg(t_reg_index idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4*idx); pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // send one item, idling the sender at random beforehand; valid drops
    // when the sender idles or when the stimulus settles
    task automatic send_item(t_action act, logic [VALUE_W-1:0] value,
                             logic [LAG_W-1:0] lag, logic [CHAN_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.sample_value <= value;
        in_ch.lag_index <= lag;
        in_ch.channel_index <= ch;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // wait for results to drain and the block to go quiet before a register write
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0 || !in_ch.ready) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic set_shape(int unsigned lags, int unsigned chans);
        settle();
        write_reg(REG_NUM_LAGS, lags);
        write_reg(REG_NUM_CHANNELS, chans);
        chans_cfg = (chans < 1) ? 1 : ((chans > 8) ? 8 : chans);
    endtask

    // a full sample of random values, biased to extremes now and then
    task automatic push_sample();
        logic [VALUE_W-1:0] v;
        for (int c = 0; c < chans_cfg; c++) begin
            case ($urandom_range(5))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                default: v = $urandom;
            endcase
            send_item(ACT_PUSH, v, LAG_W'($urandom), CHAN_W'($urandom));
        end
    endtask

    task automatic random_phase(int n);
        int k;
        k = 0;
        while (k < n) begin
            case ($urandom_range(19))
                0: begin
                    send_item(ACT_CLEAR, $urandom, LAG_W'($urandom), CHAN_W'($urandom));
                    k++;
                end
                1: begin
                    send_item(ACT_NOP, $urandom, LAG_W'($urandom), CHAN_W'($urandom));
                end
                2, 3: begin
                    send_item(ACT_PUSH, $urandom, LAG_W'($urandom), CHAN_W'($urandom));
                    k++;
                end
                4, 5, 6, 7, 8, 9: begin
                    send_item(ACT_READ, $urandom, LAG_W'($urandom), CHAN_W'($urandom));
                    k++;
                end
                default: begin push_sample(); k += chans_cfg; end
            endcase
        end
    endtask

    initial begin
        send_idle_pct = 25; recv_idle_pct = 59;
        chans_cfg = 1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every action, out-of-range reads, saturation
        for (int i = 0; i < 4; i++) send_item(ACT_PUSH, 32'h8000_0000, 0, 0);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_READ, 0, 3, 0);
        send_item(ACT_READ, 0, 63, 7);
        send_item(ACT_PUSH, 32'h7fff_ffff, 0, 0);
        send_item(ACT_PUSH, 32'hffff_ffff, 0, 0);
        send_item(ACT_READ, 0, 1, 0);
        send_item(ACT_READ, 0, 0, 1);
        send_item(ACT_NOP, 32'h5555_aaaa, 6'h2a, 3'h5);
        send_item(ACT_CLEAR, 0, 0, 0);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_PUSH, 32'h0001_0000, 0, 0);
        send_item(ACT_READ, 0, 0, 0);
        send_item(ACT_READ, 0, 1, 0);

        // registers out of range clamp: 0 lags -> 1, 15 channels -> 8
        set_shape(0, 15);
        repeat (2) push_sample();
        send_item(ACT_READ, 0, 0, 7);
        send_item(ACT_READ, 0, 1, 0);
        set_shape(127, 0);
        random_phase(60);

        // sweep of shapes and idling schedules
        set_shape(3, 2);
        random_phase(70);
        send_idle_pct = 59; recv_idle_pct = 25;
        set_shape(64, 8);
        random_phase(90);
        set_shape(1, 8);
        random_phase(60);
        set_shape(5, 3);
        random_phase(70);
        send_idle_pct = 0; recv_idle_pct = 0;
        set_shape(2, 1);
        random_phase(60);
        set_shape(64, 1);
        random_phase(100);

        settle();
        if (fail_count == 0)
            $display("multichannel_autocorrelator_core verification clean");
        else
            $display("multichannel_autocorrelator_core verification failed");
        $finish;
    end
endmodule
